>>> src/nps_pkg.sv
`timescale 1ns / 1ps

package nps_pkg;

  // Field widths fixed by the word format
  localparam int unsigned IdW   = 8;
  localparam int unsigned TickW = 16;
  localparam int unsigned PrioW = 8;
  localparam int unsigned SumW  = 32;

  // Operation codes of an input word
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_ADD  = 1'b1
  } op_e;

  // One stored job
  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TickW-1:0] arrival;
    logic [TickW-1:0] burst;
    logic [TickW-1:0] remaining;
    logic [PrioW-1:0] prio;
  } slot_t;

  // Control of the selection unit
  typedef struct packed {
    logic clear;  // start a new search
    logic en;     // evaluate the candidate this cycle
  } pick_ctl_t;

endpackage

>>> src/nps_slot_mem.sv
`timescale 1ns / 1ps

module nps_slot_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned IdxW  = 4
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [IdxW-1:0]     wr_addr_i,
  input  nps_pkg::slot_t      wr_data_i,
  input  logic [IdxW-1:0]     rd_addr_i,
  output nps_pkg::slot_t      rd_data_o
);

  nps_pkg::slot_t mem_q [Depth];
  nps_pkg::slot_t rd_data_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> src/nps_pick.sv
`timescale 1ns / 1ps

module nps_pick #(
  parameter int unsigned IdxW = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  nps_pkg::pick_ctl_t             ctl_i,
  input  logic                           cand_valid_i,
  input  logic [IdxW-1:0]                cand_idx_i,
  input  logic [nps_pkg::TickW-1:0]      cand_arrival_i,
  input  logic [nps_pkg::PrioW-1:0]      cand_prio_i,
  input  logic [nps_pkg::TickW-1:0]      now_i,
  output logic                           found_o,
  output logic [IdxW-1:0]                best_idx_o
);

  logic                      found_q;
  logic [IdxW-1:0]           best_idx_q;
  logic [nps_pkg::TickW-1:0] best_arr_q;
  logic [nps_pkg::PrioW-1:0] best_prio_q;
  logic                      eligible;
  logic                      better;

  // Candidate wins on lower priority number, then earlier arrival;
  // slots come in ascending order so an exact tie keeps the lower slot.
  assign eligible = cand_valid_i && (cand_arrival_i <= now_i);
  assign better   = !found_q || (cand_prio_i < best_prio_q) ||
                    ((cand_prio_i == best_prio_q) && (cand_arrival_i < best_arr_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctl_i.clear) begin
      found_q <= 1'b0;
    end else if (ctl_i.en && eligible) begin
      found_q <= 1'b1;
    end
  end

  // Best-so-far payload
  always_ff @(posedge clk_i) begin
    if (!ctl_i.clear && ctl_i.en && eligible && better) begin
      best_idx_q  <= cand_idx_i;
      best_arr_q  <= cand_arrival_i;
      best_prio_q <= cand_prio_i;
    end
  end

  assign found_o    = found_q;
  assign best_idx_o = best_idx_q;

endmodule

>>> src/nonpreemptive_priority_scheduler_top.sv
`timescale 1ns / 1ps
// Per input word, from acceptance to result: an add scans for a free slot, one slot per
// cycle; a tick with a job running reads its slot, serves it and, when the job finishes,
// adds to both totals; a tick that has to pick first scans all TABLE_DEPTH slots through
// the one read port, then serves the chosen job, if one is eligible, in the same way.
// One word in flight; the next word is accepted the cycle after the result is taken.
// Reset (async, active low) clears valid bits, running flag, tick count and both totals.
module nonpreemptive_priority_scheduler_top #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic [nps_pkg::IdW-1:0]       job_id_i,
  input  logic [nps_pkg::TickW-1:0]     arrival_i,
  input  logic [nps_pkg::TickW-1:0]     burst_i,
  input  logic [nps_pkg::PrioW-1:0]     prio_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          busy_res_o,
  output logic [nps_pkg::IdW-1:0]       running_id_o,
  output logic                          finished_o,
  output logic [nps_pkg::TickW-1:0]     wait_ticks_o,
  output logic [nps_pkg::TickW-1:0]     turnaround_ticks_o,
  output logic [nps_pkg::SumW-1:0]      total_wait_o,
  output logic [nps_pkg::SumW-1:0]      total_turnaround_o,
  output logic                          add_rejected_o,
  output logic [nps_pkg::TickW-1:0]     now_o
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_DEPTH - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_SCAN_END,
    ST_PICK,
    ST_READ,
    ST_SERVE,
    ST_ACCUM,
    ST_OUT
  } state_e;

  state_e                    state_q;
  logic [TABLE_DEPTH-1:0]    valid_q;
  logic                      running_q;
  logic [IdxW-1:0]           slot_q;
  logic [IdxW-1:0]           idx_q;
  logic                      pend_q;
  logic [IdxW-1:0]           pend_idx_q;
  logic [nps_pkg::TickW-1:0] tick_q;
  logic [nps_pkg::SumW-1:0]  wait_sum_q;
  logic [nps_pkg::SumW-1:0]  ta_sum_q;

  // Latched input word
  nps_pkg::op_e              op_q;
  logic [nps_pkg::IdW-1:0]   id_in_q;
  logic [nps_pkg::TickW-1:0] arr_in_q;
  logic [nps_pkg::TickW-1:0] burst_in_q;
  logic [nps_pkg::PrioW-1:0] prio_in_q;
  logic [nps_pkg::TickW-1:0] now_q;

  // Result registers
  logic                      busy_q;
  logic [nps_pkg::IdW-1:0]   rid_q;
  logic                      fin_q;
  logic [nps_pkg::TickW-1:0] wt_q;
  logic [nps_pkg::TickW-1:0] ta_q;
  logic [nps_pkg::TickW-1:0] fin_burst_q;
  logic                      rej_q;

  logic                      in_acc;
  logic                      mem_we;
  logic [IdxW-1:0]           mem_waddr;
  nps_pkg::slot_t            mem_wdata;
  logic [IdxW-1:0]           mem_raddr;
  nps_pkg::slot_t            rd;
  nps_pkg::pick_ctl_t        pick_ctl;
  logic                      pick_found;
  logic [IdxW-1:0]           pick_idx;
  logic [nps_pkg::TickW-1:0] tick_inc;
  logic [nps_pkg::TickW-1:0] rem_dec;
  logic [nps_pkg::TickW:0]   ta_full;
  logic [nps_pkg::TickW-1:0] ta_sat;
  logic [nps_pkg::TickW-1:0] wt_calc;
  logic [nps_pkg::SumW:0]    wait_add;
  logic [nps_pkg::SumW:0]    ta_add;

  assign in_acc = in_valid_i && !in_stall_o;

  // Slot storage
  nps_slot_mem #(
    .Depth (TABLE_DEPTH),
    .IdxW  (IdxW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata),
    .rd_addr_i (mem_raddr),
    .rd_data_o (rd)
  );

  // Shared selection compare unit
  assign pick_ctl.clear = in_acc;
  assign pick_ctl.en    = pend_q;

  nps_pick #(
    .IdxW (IdxW)
  ) u_pick (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (pick_ctl),
    .cand_valid_i   (valid_q[pend_idx_q]),
    .cand_idx_i     (pend_idx_q),
    .cand_arrival_i (rd.arrival),
    .cand_prio_i    (rd.prio),
    .now_i          (now_q),
    .found_o        (pick_found),
    .best_idx_o     (pick_idx)
  );

  // Memory port steering
  always_comb begin
    mem_raddr = (state_q == ST_SCAN) ? idx_q : slot_q;
    mem_we    = 1'b0;
    mem_waddr = slot_q;
    mem_wdata = rd;
    mem_wdata.remaining = rem_dec;
    if (state_q == ST_ADD) begin
      mem_we    = !valid_q[idx_q];
      mem_waddr = idx_q;
      mem_wdata = '{id: id_in_q, arrival: arr_in_q, burst: burst_in_q,
                    remaining: burst_in_q, prio: prio_in_q};
    end else if (state_q == ST_SERVE) begin
      mem_we = 1'b1;
    end
  end

  // Service arithmetic
  assign tick_inc = (tick_q != '1) ? tick_q + 1'b1 : tick_q;
  assign rem_dec  = (rd.remaining != '0) ? rd.remaining - 1'b1 : '0;
  assign ta_full  = {1'b0, now_q} + 1'b1 - {1'b0, rd.arrival};
  assign ta_sat   = ta_full[nps_pkg::TickW] ? '1 : ta_full[nps_pkg::TickW-1:0];
  assign wt_calc  = (ta_q >= fin_burst_q) ? ta_q - fin_burst_q : '0;
  assign wait_add = {1'b0, wait_sum_q} + {{(nps_pkg::SumW-nps_pkg::TickW+1){1'b0}}, wt_calc};
  assign ta_add   = {1'b0, ta_sum_q} + {{(nps_pkg::SumW-nps_pkg::TickW+1){1'b0}}, ta_q};

  // Sequencer and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      valid_q    <= '0;
      running_q  <= 1'b0;
      slot_q     <= '0;
      idx_q      <= '0;
      pend_q     <= 1'b0;
      pend_idx_q <= '0;
      tick_q     <= '0;
      wait_sum_q <= '0;
      ta_sum_q   <= '0;
    end else begin
      pend_q     <= (state_q == ST_SCAN);
      pend_idx_q <= idx_q;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            idx_q <= '0;
            if (nps_pkg::op_e'(operation_i) == nps_pkg::OP_ADD) begin
              state_q <= ST_ADD;
            end else if (running_q) begin
              state_q <= ST_READ;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_ADD: begin
          if (!valid_q[idx_q]) begin
            valid_q[idx_q] <= 1'b1;
            state_q        <= ST_OUT;
          end else if (idx_q == LastIdx) begin
            state_q <= ST_OUT;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_SCAN: begin
          if (idx_q == LastIdx) begin
            state_q <= ST_SCAN_END;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_SCAN_END: begin
          state_q <= ST_PICK;
        end
        ST_PICK: begin
          if (pick_found) begin
            running_q <= 1'b1;
            slot_q    <= pick_idx;
            state_q   <= ST_READ;
          end else begin
            tick_q  <= tick_inc;
            state_q <= ST_OUT;
          end
        end
        ST_READ: begin
          state_q <= ST_SERVE;
        end
        ST_SERVE: begin
          if (rem_dec == '0) begin
            valid_q[slot_q] <= 1'b0;
            running_q       <= 1'b0;
            state_q         <= ST_ACCUM;
          end else begin
            tick_q  <= tick_inc;
            state_q <= ST_OUT;
          end
        end
        ST_ACCUM: begin
          wait_sum_q <= wait_add[nps_pkg::SumW] ? '1 : wait_add[nps_pkg::SumW-1:0];
          ta_sum_q   <= ta_add[nps_pkg::SumW] ? '1 : ta_add[nps_pkg::SumW-1:0];
          tick_q     <= tick_inc;
          state_q    <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_stall_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Input latch and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q       <= nps_pkg::op_e'(operation_i);
      id_in_q    <= job_id_i;
      arr_in_q   <= arrival_i;
      burst_in_q <= burst_i;
      prio_in_q  <= prio_i;
      now_q      <= tick_q;
      busy_q     <= 1'b0;
      rid_q      <= '0;
      fin_q      <= 1'b0;
      wt_q       <= '0;
      ta_q       <= '0;
      rej_q      <= 1'b0;
    end else begin
      if (state_q == ST_ADD && valid_q[idx_q] && idx_q == LastIdx) begin
        rej_q <= 1'b1;
      end
      if (state_q == ST_SERVE) begin
        busy_q <= 1'b1;
        rid_q  <= rd.id;
        if (rem_dec == '0) begin
          fin_q       <= 1'b1;
          ta_q        <= ta_sat;
          fin_burst_q <= rd.burst;
        end
      end
      if (state_q == ST_ACCUM) begin
        wt_q <= wt_calc;
      end
    end
  end

  assign in_stall_o         = (state_q != ST_IDLE);
  assign out_valid_o        = (state_q == ST_OUT);
  assign busy_res_o         = busy_q;
  assign running_id_o       = rid_q;
  assign finished_o         = fin_q;
  assign wait_ticks_o       = wt_q;
  assign turnaround_ticks_o = ta_q;
  assign total_wait_o       = wait_sum_q;
  assign total_turnaround_o = ta_sum_q;
  assign add_rejected_o     = rej_q;
  assign now_o              = now_q;

  // Checks
  a_fin_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o |-> busy_res_o)
    else $error("finished job reported without service");

  a_add_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && op_q == nps_pkg::OP_ADD |-> !busy_res_o && !finished_o)
    else $error("add word reported service");

  a_run_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> valid_q[slot_q])
    else $error("running job sits in a free slot");

  a_sum_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> total_wait_o >= $past(total_wait_o))
    else $error("wait total decreased");

  a_tick_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ADD |=> tick_q == $past(tick_q))
    else $error("add word advanced time");

endmodule

>>> sim/nonpreemptive_priority_scheduler_check.sv
`timescale 1ns / 1ps

module nonpreemptive_priority_scheduler_check #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic                      operation_i,
  input  logic [nps_pkg::IdW-1:0]   job_id_i,
  input  logic [nps_pkg::TickW-1:0] arrival_i,
  input  logic [nps_pkg::TickW-1:0] burst_i,
  input  logic [nps_pkg::PrioW-1:0] prio_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic                      busy_res_i,
  input  logic [nps_pkg::IdW-1:0]   running_id_i,
  input  logic                      finished_i,
  input  logic [nps_pkg::TickW-1:0] wait_ticks_i,
  input  logic [nps_pkg::TickW-1:0] turnaround_ticks_i,
  input  logic [nps_pkg::SumW-1:0]  total_wait_i,
  input  logic [nps_pkg::SumW-1:0]  total_turnaround_i,
  input  logic                      add_rejected_i,
  input  logic [nps_pkg::TickW-1:0] now_i,
  output int unsigned               mismatch_o,
  output int unsigned               pending_o
);

  localparam int unsigned IdW   = nps_pkg::IdW;
  localparam int unsigned TickW = nps_pkg::TickW;
  localparam int unsigned PrioW = nps_pkg::PrioW;
  localparam int unsigned SumW  = nps_pkg::SumW;
  localparam logic [TickW-1:0] TickMax = '1;

  // One result word as the block reports it
  typedef struct packed {
    logic             busy;
    logic [IdW-1:0]   run_id;
    logic             fin;
    logic [TickW-1:0] wait_t;
    logic [TickW-1:0] turn_t;
    logic [SumW-1:0]  wait_tot;
    logic [SumW-1:0]  turn_tot;
    logic             rej;
    logic [TickW-1:0] now;
  } report_t;

  // Shadow copy of the job table and scheduler state
  nps_pkg::slot_t   jobs     [TABLE_DEPTH];
  logic             job_live [TABLE_DEPTH];
  logic             serving;
  int unsigned      serve_slot;
  logic [TickW-1:0] clock_ticks;
  logic [SumW-1:0]  wait_acc;
  logic [SumW-1:0]  turn_acc;
  report_t          report_q[$];
  int unsigned      errors = 0;

  function automatic logic [SumW-1:0] add_sat(logic [SumW-1:0] a, logic [SumW-1:0] b);
    logic [SumW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SumW] ? '1 : s[SumW-1:0];
  endfunction

  // Apply one input word to the shadow state, return the report it causes
  function automatic report_t next_report(nps_pkg::op_e op, logic [IdW-1:0] id,
                                          logic [TickW-1:0] arr, logic [TickW-1:0] bur,
                                          logic [PrioW-1:0] pr);
    report_t     r;
    int unsigned best;
    logic        found;
    int          span;
    r     = '0;
    r.now = clock_ticks;
    found = 1'b0;
    best  = 0;
    if (op == nps_pkg::OP_ADD) begin
      // lowest free slot takes the job
      r.rej = 1'b1;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (!found && !job_live[i]) begin
          job_live[i] = 1'b1;
          jobs[i]     = '{id: id, arrival: arr, burst: bur, remaining: bur, prio: pr};
          found       = 1'b1;
          r.rej       = 1'b0;
        end
      end
    end else begin
      // pick: lowest prio, then earliest arrival, then lowest slot
      if (!serving) begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (job_live[i] && jobs[i].arrival <= clock_ticks) begin
            if (!found || jobs[i].prio < jobs[best].prio ||
                (jobs[i].prio == jobs[best].prio &&
                 jobs[i].arrival < jobs[best].arrival)) begin
              best  = i;
              found = 1'b1;
            end
          end
        end
        if (found) begin
          serving    = 1'b1;
          serve_slot = best;
        end
      end
      // serve one tick
      if (serving) begin
        r.busy   = 1'b1;
        r.run_id = jobs[serve_slot].id;
        if (jobs[serve_slot].remaining != '0)
          jobs[serve_slot].remaining = jobs[serve_slot].remaining - 1'b1;
        if (jobs[serve_slot].remaining == '0) begin
          span = int'(clock_ticks) + 1 - int'(jobs[serve_slot].arrival);
          if (span > int'(TickMax)) span = int'(TickMax);
          r.turn_t = TickW'(span);
          r.wait_t = (span >= int'(jobs[serve_slot].burst)) ?
                     TickW'(span - int'(jobs[serve_slot].burst)) : '0;
          r.fin    = 1'b1;
          wait_acc = add_sat(wait_acc, SumW'(r.wait_t));
          turn_acc = add_sat(turn_acc, SumW'(r.turn_t));
          job_live[serve_slot] = 1'b0;
          serving  = 1'b0;
        end
      end
      if (clock_ticks != TickMax) clock_ticks = clock_ticks + 1'b1;
    end
    r.wait_tot = wait_acc;
    r.turn_tot = turn_acc;
    return r;
  endfunction

  function automatic void check_field(string fname, logic [SumW-1:0] want,
                                      logic [SumW-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h, actual %0h", $time, fname, want, got);
    end
  endfunction

  // Watch both channels; predict on input words, compare on output words
  always @(posedge clk_i) begin
    report_t got;
    report_t want;
    report_t fresh;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        job_live[i] = 1'b0;
        jobs[i]     = '0;
      end
      serving     = 1'b0;
      serve_slot  = 0;
      clock_ticks = '0;
      wait_acc    = '0;
      turn_acc    = '0;
      report_q.delete();
    end else begin
      if (in_valid_i === 1'b1 && in_stall_i === 1'b0) begin
        fresh    = next_report(nps_pkg::op_e'(operation_i), job_id_i, arrival_i,
                               burst_i, prio_i);
        report_q = {report_q, fresh};
      end
      if (out_valid_i === 1'b1 && out_stall_i === 1'b0) begin
        got = '{busy: busy_res_i, run_id: running_id_i, fin: finished_i,
                wait_t: wait_ticks_i, turn_t: turnaround_ticks_i,
                wait_tot: total_wait_i, turn_tot: total_turnaround_i,
                rej: add_rejected_i, now: now_i};
        if (report_q.size() == 0) begin
          errors++;
          $display("%0t: result word with none predicted, actual now %0h", $time, now_i);
        end else begin
          want = report_q.pop_front();
          check_field("busy_res", SumW'(want.busy), SumW'(got.busy));
          check_field("running_id", SumW'(want.run_id), SumW'(got.run_id));
          check_field("finished", SumW'(want.fin), SumW'(got.fin));
          check_field("wait_ticks", SumW'(want.wait_t), SumW'(got.wait_t));
          check_field("turnaround_ticks", SumW'(want.turn_t), SumW'(got.turn_t));
          check_field("total_wait", want.wait_tot, got.wait_tot);
          check_field("total_turnaround", want.turn_tot, got.turn_tot);
          check_field("add_rejected", SumW'(want.rej), SumW'(got.rej));
          check_field("now", SumW'(want.now), SumW'(got.now));
        end
      end
    end
    mismatch_o <= errors;
    pending_o  <= report_q.size();
  end

endmodule

>>> sim/nonpreemptive_priority_scheduler_top_test.sv
`timescale 1ns / 1ps

module nonpreemptive_priority_scheduler_top_test;

  localparam int unsigned IdW   = nps_pkg::IdW;
  localparam int unsigned TickW = nps_pkg::TickW;
  localparam int unsigned PrioW = nps_pkg::PrioW;
  localparam int unsigned SumW  = nps_pkg::SumW;

  localparam int unsigned TABLE_DEPTH  = 16;
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned PHASE_WORDS  = 135;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam logic [TickW-1:0] TickMax = '1;

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  logic             operation = nps_pkg::OP_TICK;
  logic [IdW-1:0]   job_id    = '0;
  logic [TickW-1:0] arrival   = '0;
  logic [TickW-1:0] burst     = '0;
  logic [PrioW-1:0] prio      = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             busy_res;
  logic [IdW-1:0]   running_id;
  logic             finished;
  logic [TickW-1:0] wait_ticks;
  logic [TickW-1:0] turnaround_ticks;
  logic [SumW-1:0]  total_wait;
  logic [SumW-1:0]  total_turnaround;
  logic             add_rejected;
  logic [TickW-1:0] now;

  int unsigned      mismatches;
  int unsigned      pending;
  int unsigned      gap_pct     = 0;
  int unsigned      stall_pct   = 0;
  int unsigned      words_taken = 0;
  int unsigned      idle_cycles = 0;
  logic [TickW-1:0] ticks_sent  = '0;
  int unsigned      far_left    = 4;
  int unsigned      gap_plan   [4] = '{0, 71, 0, 30};
  int unsigned      stall_plan [4] = '{0, 0, 71, 30};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  nonpreemptive_priority_scheduler_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .operation_i        (operation),
    .job_id_i           (job_id),
    .arrival_i          (arrival),
    .burst_i            (burst),
    .prio_i             (prio),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .busy_res_o         (busy_res),
    .running_id_o       (running_id),
    .finished_o         (finished),
    .wait_ticks_o       (wait_ticks),
    .turnaround_ticks_o (turnaround_ticks),
    .total_wait_o       (total_wait),
    .total_turnaround_o (total_turnaround),
    .add_rejected_o     (add_rejected),
    .now_o              (now)
  );

  nonpreemptive_priority_scheduler_check #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) sched_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .operation_i        (operation),
    .job_id_i           (job_id),
    .arrival_i          (arrival),
    .burst_i            (burst),
    .prio_i             (prio),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .busy_res_i         (busy_res),
    .running_id_i       (running_id),
    .finished_i         (finished),
    .wait_ticks_i       (wait_ticks),
    .turnaround_ticks_i (turnaround_ticks),
    .total_wait_i       (total_wait),
    .total_turnaround_i (total_turnaround),
    .add_rejected_i     (add_rejected),
    .now_i              (now),
    .mismatch_o         (mismatches),
    .pending_o          (pending)
  );

  // Watchdog on cycles with no word moving on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) words_taken <= words_taken + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("nonpreemptive_priority_scheduler_top regression: fail");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus one long hold-off to back up the input
  initial begin : out_side
    logic held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && words_taken >= 40) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Offer one word, with an optional random gap ahead of it
  task automatic send_word(input nps_pkg::op_e op, input logic [IdW-1:0] id,
                           input logic [TickW-1:0] arr, input logic [TickW-1:0] bur,
                           input logic [PrioW-1:0] pr);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < gap_pct);
    end
    in_valid  <= 1'b1;
    operation <= op;
    job_id    <= id;
    arrival   <= arr;
    burst     <= bur;
    prio      <= pr;
    do @(posedge clk_i); while (in_stall !== 1'b0);
    if (op == nps_pkg::OP_TICK && ticks_sent != TickMax) ticks_sent = ticks_sent + 1'b1;
  endtask

  // Tick word; the job fields are don't-care and get noise
  task automatic send_tick();
    send_word(nps_pkg::OP_TICK, IdW'($urandom), TickW'($urandom), TickW'($urandom),
              PrioW'($urandom));
  endtask

  initial begin : stimulus
    int                arr_i;
    int unsigned       pick;
    logic [TickW-1:0]  bur;
    logic [PrioW-1:0]  pr;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: idle tick, fill the table with tie cases, then one add too many
    send_tick();
    send_word(nps_pkg::OP_ADD, 8'd0,   16'd0, 16'd2, 8'd5);
    send_word(nps_pkg::OP_ADD, 8'd255, 16'd0, 16'd1, 8'd255);
    send_word(nps_pkg::OP_ADD, 8'd1,   16'd0, 16'd0, 8'd5);     // zero burst, full tie
    send_word(nps_pkg::OP_ADD, 8'd2,   16'd1, 16'd1, 8'd0);
    send_word(nps_pkg::OP_ADD, 8'd3,   TickMax, 16'd1, 8'd0);   // never eligible here
    send_word(nps_pkg::OP_ADD, 8'd4,   16'd3, 16'd1, 8'd0);     // future arrival
    send_word(nps_pkg::OP_ADD, 8'd5,   16'd2, 16'd3, 8'd7);
    send_word(nps_pkg::OP_ADD, 8'd6,   16'd1, 16'd1, 8'd7);     // earlier arrival wins
    for (int k = 0; k < 8; k++)
      send_word(nps_pkg::OP_ADD, IdW'(7 + k), TickW'(k % 2), TickW'(1 + k % 2),
                PrioW'(100 + k));
    send_word(nps_pkg::OP_ADD, 8'd99, 16'd0, 16'd1, 8'd1);     // table full
    repeat (5) send_tick();

    // Random mix of adds and ticks over the gap and stall phases
    for (int n = 0; n < 4 * PHASE_WORDS; n++) begin
      if (n % PHASE_WORDS == 0) begin
        gap_pct   = gap_plan[n / PHASE_WORDS];
        stall_pct = stall_plan[n / PHASE_WORDS];
      end
      if ($urandom_range(0, 99) < 30) begin
        pick = $urandom_range(0, 99);
        if (far_left != 0 && pick == 99) begin
          far_left--;
          arr_i = $urandom_range(0, 65535);
        end else if (pick < 50) begin
          arr_i = int'(ticks_sent) + $urandom_range(0, 8);
          if (arr_i > int'(TickMax)) arr_i = int'(TickMax);
        end else begin
          arr_i = $urandom_range(0, ticks_sent);
        end
        bur = ($urandom_range(0, 99) < 80) ? TickW'($urandom_range(1, 6))
                                           : TickW'($urandom_range(7, 40));
        pr  = $urandom_range(0, 1) ? PrioW'($urandom_range(0, 255))
                                   : PrioW'($urandom_range(0, 3));
        send_word(nps_pkg::OP_ADD, IdW'($urandom), TickW'(arr_i), bur, pr);
      end else begin
        send_tick();
      end
    end

    // A few closing ticks with free flow
    gap_pct   = 0;
    stall_pct = 0;
    repeat (30) send_tick();
    in_valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0)
      $display("nonpreemptive_priority_scheduler_top regression: pass");
    else
      $display("nonpreemptive_priority_scheduler_top regression: fail");
    $finish;
  end

endmodule
